// File: hw/rtl/pit_pkg.sv
package pit_pkg;

    localparam int ACT_W  = 2;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 16;
    localparam int IRQ_W  = 4;

    // Action codes carried by each input word
    typedef enum logic [ACT_W-1:0] {
        ACT_TICK  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2
    } action_t;

    // Register map
    localparam logic [ADDR_W-1:0] ADDR_ENABLE   = 4'd0;
    localparam logic [ADDR_W-1:0] ADDR_FORCE    = 4'd1;
    localparam logic [ADDR_W-1:0] ADDR_CHAN_EN  = 4'd2;
    localparam logic [ADDR_W-1:0] ADDR_MUX      = 4'd3;
    localparam logic [ADDR_W-1:0] ADDR_INTE     = 4'd4;
    localparam logic [ADDR_W-1:0] ADDR_FLAGS    = 4'd5;
    localparam logic [ADDR_W-1:0] ADDR_MTLOAD0  = 4'd6;
    localparam logic [ADDR_W-1:0] ADDR_MTLOAD1  = 4'd7;
    localparam logic [ADDR_W-1:0] ADDR_LOAD0    = 4'd8;
    localparam logic [ADDR_W-1:0] ADDR_LOAD3    = 4'd11;
    localparam logic [ADDR_W-1:0] ADDR_COUNT0   = 4'd12;
    localparam logic [ADDR_W-1:0] ADDR_COUNT3   = 4'd15;

    // Bit of the enable register that holds the global enable
    localparam int GLOBAL_EN_BIT = 7;

    // Number of load and count slots the register map can reach
    localparam int MAP_MICROS = 2;
    localparam int MAP_CHANS  = 4;

    typedef struct packed {
        action_t             action;
        logic [ADDR_W-1:0]   address;
        logic [DATA_W-1:0]   write_data;
    } pit_req_t;

    typedef struct packed {
        logic [DATA_W-1:0]   read_data;
        logic [IRQ_W-1:0]    irq_lines;
    } pit_rsp_t;

endpackage

// File: hw/rtl/pit_core.sv
module pit_core #(
    parameter int NUM_CHANNELS    = 4,
    parameter int NUM_MICROTIMERS = 2,
    parameter int CHAN_BITS       = 16,
    parameter int MICRO_BITS      = 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            fire,
    input  pit_pkg::pit_req_t req,
    output pit_pkg::pit_rsp_t rsp
);
    import pit_pkg::*;

    logic                       ge_reg, ge_next;
    logic [NUM_CHANNELS-1:0]    en_reg, en_next;
    logic [NUM_CHANNELS-1:0]    sel_reg, sel_next;
    logic [NUM_CHANNELS-1:0]    ie_reg, ie_next;
    logic [NUM_CHANNELS-1:0]    flags_reg, flags_next;
    logic [MICRO_BITS-1:0]      mt_load_reg [NUM_MICROTIMERS];
    logic [MICRO_BITS-1:0]      mt_load_next [NUM_MICROTIMERS];
    logic [MICRO_BITS-1:0]      mt_cnt_reg [NUM_MICROTIMERS];
    logic [MICRO_BITS-1:0]      mt_cnt_next [NUM_MICROTIMERS];
    logic [CHAN_BITS-1:0]       ch_load_reg [NUM_CHANNELS];
    logic [CHAN_BITS-1:0]       ch_load_next [NUM_CHANNELS];
    logic [CHAN_BITS-1:0]       ch_cnt_reg [NUM_CHANNELS];
    logic [CHAN_BITS-1:0]       ch_cnt_next [NUM_CHANNELS];

    logic [NUM_MICROTIMERS-1:0] trig;
    logic [1:0]                 trig_sel;
    logic [NUM_CHANNELS-1:0]    hit;
    logic [NUM_CHANNELS-1:0]    chm;
    logic [DATA_W-1:0]          rd_word;

    // Microtimers found at zero fire a trigger
    always_comb begin
        for (int m = 0; m < NUM_MICROTIMERS; m++) begin
            trig[m] = (mt_cnt_reg[m] == '0);
        end
        trig_sel[0] = trig[0];
        trig_sel[1] = (NUM_MICROTIMERS > 1) ? trig[(NUM_MICROTIMERS > 1) ? 1 : 0] : 1'b0;
    end

    // Channels that step on this tick
    always_comb begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            hit[c] = en_reg[c] && (sel_reg[c] ? trig_sel[1] : trig_sel[0]);
        end
    end

    assign chm = req.write_data[NUM_CHANNELS-1:0];

    // Register read mux
    always_comb begin
        rd_word = '0;
        case (req.address)
            ADDR_ENABLE:  rd_word[GLOBAL_EN_BIT] = ge_reg;
            ADDR_CHAN_EN: rd_word = DATA_W'(en_reg);
            ADDR_MUX:     rd_word = DATA_W'(sel_reg);
            ADDR_INTE:    rd_word = DATA_W'(ie_reg);
            ADDR_FLAGS:   rd_word = DATA_W'(flags_reg);
            default: begin
                if (req.address inside {[ADDR_MTLOAD0:ADDR_MTLOAD1]}) begin
                    for (int m = 0; m < NUM_MICROTIMERS; m++) begin
                        if (m < MAP_MICROS && req.address[0] == 1'(m)) begin
                            rd_word = DATA_W'(32'(mt_load_reg[m]));
                        end
                    end
                end else if (req.address inside {[ADDR_LOAD0:ADDR_LOAD3]}) begin
                    for (int c = 0; c < NUM_CHANNELS; c++) begin
                        if (c < MAP_CHANS && req.address[1:0] == 2'(c)) begin
                            rd_word = DATA_W'(32'(ch_load_reg[c]));
                        end
                    end
                end else if (req.address inside {[ADDR_COUNT0:ADDR_COUNT3]}) begin
                    for (int c = 0; c < NUM_CHANNELS; c++) begin
                        if (c < MAP_CHANS && req.address[1:0] == 2'(c)) begin
                            rd_word = DATA_W'(32'(ch_cnt_reg[c]));
                        end
                    end
                end
            end
        endcase
    end

    // Next state and response for the word in hand
    always_comb begin
        ge_next      = ge_reg;
        en_next      = en_reg;
        sel_next     = sel_reg;
        ie_next      = ie_reg;
        flags_next   = flags_reg;
        mt_load_next = mt_load_reg;
        mt_cnt_next  = mt_cnt_reg;
        ch_load_next = ch_load_reg;
        ch_cnt_next  = ch_cnt_reg;
        rsp.read_data = '0;
        case (req.action)
            ACT_TICK: begin
                if (ge_reg) begin
                    for (int m = 0; m < NUM_MICROTIMERS; m++) begin
                        mt_cnt_next[m] = trig[m] ? mt_load_reg[m]
                                                 : mt_cnt_reg[m] - MICRO_BITS'(1);
                    end
                    for (int c = 0; c < NUM_CHANNELS; c++) begin
                        if (hit[c]) begin
                            if (ch_cnt_reg[c] == '0) begin
                                ch_cnt_next[c] = ch_load_reg[c];
                                flags_next[c]  = 1'b1;
                            end else begin
                                ch_cnt_next[c] = ch_cnt_reg[c] - CHAN_BITS'(1);
                            end
                        end
                    end
                end
            end
            ACT_READ: begin
                rsp.read_data = rd_word;
            end
            ACT_WRITE: begin
                case (req.address)
                    ADDR_ENABLE: begin
                        // Rising enable reloads every counter, falling clears flags
                        if (req.write_data[GLOBAL_EN_BIT] && !ge_reg) begin
                            mt_cnt_next = mt_load_reg;
                            ch_cnt_next = ch_load_reg;
                        end
                        if (!req.write_data[GLOBAL_EN_BIT] && ge_reg) begin
                            flags_next = '0;
                        end
                        ge_next = req.write_data[GLOBAL_EN_BIT];
                        for (int m = 0; m < NUM_MICROTIMERS; m++) begin
                            if (req.write_data[m]) begin
                                mt_cnt_next[m] = mt_load_reg[m];
                            end
                        end
                    end
                    ADDR_FORCE: begin
                        for (int c = 0; c < NUM_CHANNELS; c++) begin
                            if (chm[c]) begin
                                ch_cnt_next[c] = ch_load_reg[c];
                            end
                        end
                    end
                    ADDR_CHAN_EN: begin
                        for (int c = 0; c < NUM_CHANNELS; c++) begin
                            if (chm[c] && !en_reg[c]) begin
                                ch_cnt_next[c] = ch_load_reg[c];
                            end
                        end
                        en_next = chm;
                    end
                    ADDR_MUX:   sel_next = chm;
                    ADDR_INTE:  ie_next = chm;
                    ADDR_FLAGS: flags_next = flags_reg & ~chm;
                    default: begin
                        if (req.address inside {[ADDR_MTLOAD0:ADDR_MTLOAD1]}) begin
                            for (int m = 0; m < NUM_MICROTIMERS; m++) begin
                                if (m < MAP_MICROS && req.address[0] == 1'(m)) begin
                                    mt_load_next[m] = MICRO_BITS'(req.write_data);
                                end
                            end
                        end else if (req.address inside {[ADDR_LOAD0:ADDR_LOAD3]}) begin
                            for (int c = 0; c < NUM_CHANNELS; c++) begin
                                if (c < MAP_CHANS && req.address[1:0] == 2'(c)) begin
                                    ch_load_next[c] = CHAN_BITS'(req.write_data);
                                end
                            end
                        end
                    end
                endcase
            end
            default: ;
        endcase
        rsp.irq_lines = IRQ_W'(flags_next & ie_next);
    end

    // Commit state when a word passes through
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ge_reg    <= 1'b0;
            en_reg    <= '0;
            sel_reg   <= '0;
            ie_reg    <= '0;
            flags_reg <= '0;
            for (int m = 0; m < NUM_MICROTIMERS; m++) begin
                mt_load_reg[m] <= '0;
                mt_cnt_reg[m]  <= '0;
            end
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                ch_load_reg[c] <= '0;
                ch_cnt_reg[c]  <= '0;
            end
        end else if (fire) begin
            ge_reg      <= ge_next;
            en_reg      <= en_next;
            sel_reg     <= sel_next;
            ie_reg      <= ie_next;
            flags_reg   <= flags_next;
            mt_load_reg <= mt_load_next;
            mt_cnt_reg  <= mt_cnt_next;
            ch_load_reg <= ch_load_next;
            ch_cnt_reg  <= ch_cnt_next;
        end
    end

`ifndef SYNTHESIS
    // Ticks while disabled leave the flags alone
    a_idle_tick_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && req.action == ACT_TICK && !ge_reg |=> $stable(flags_reg))
        else $error("flags changed on a tick while disabled");

    // Turning the module off clears every flag
    a_disable_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && req.action == ACT_WRITE && req.address == ADDR_ENABLE && ge_reg
        && !req.write_data[GLOBAL_EN_BIT] |=> flags_reg == '0)
        else $error("flags survived a disable");

    // Without a word passing through, control state holds
    a_hold_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(flags_reg) && $stable(ge_reg) && $stable(en_reg)
        && $stable(ie_reg))
        else $error("control state changed without a word");
`endif

endmodule

// File: hw/rtl/periodic_interrupt_timer_top.sv
// Periodic interrupt timer with NUM_CHANNELS down-counting channels of CHAN_BITS bits, each
// clocked by one of NUM_MICROTIMERS prescale microtimers of MICRO_BITS bits. Every input word
// is a tick, a register read or a register write; every word gives exactly one result word
// carrying the read data (zero unless a read) and the interrupt lines after the action.
// A word is taken into an input register, applied to the timer state by combinational logic
// and its result held in an output register: one word per clock cycle sustained while m_ready
// stays high, the result registered once the output register is free or draining, with the
// output register letting the next word enter while a result still waits.
module periodic_interrupt_timer_top #(
    parameter int NUM_CHANNELS    = 4,
    parameter int NUM_MICROTIMERS = 2,
    parameter int CHAN_BITS       = 16,
    parameter int MICRO_BITS      = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [3:0]  s_address,
    input  logic [15:0] s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_read_data,
    output logic [3:0]  m_irq_lines
);
    import pit_pkg::*;

    logic     in_valid_reg, in_valid_next;
    pit_req_t in_req_reg;
    logic     out_valid_reg, out_valid_next;
    pit_rsp_t out_rsp_reg;
    pit_rsp_t rsp;
    logic     advance;
    logic     take;

    // Move the held word on when the output register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign take    = s_valid && s_ready;

    assign in_valid_next  = take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    pit_core #(
        .NUM_CHANNELS    (NUM_CHANNELS),
        .NUM_MICROTIMERS (NUM_MICROTIMERS),
        .CHAN_BITS       (CHAN_BITS),
        .MICRO_BITS      (MICRO_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .req     (in_req_reg),
        .rsp     (rsp)
    );

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the incoming word
    always_ff @(posedge aclk) begin
        if (take) begin
            in_req_reg.action     <= action_t'(s_action);
            in_req_reg.address    <= s_address;
            in_req_reg.write_data <= s_write_data;
        end
    end

    // Hold the result word
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_rsp_reg <= rsp;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_read_data = out_rsp_reg.read_data;
    assign m_irq_lines = out_rsp_reg.irq_lines;

endmodule

// File: bench/pit_checker.sv
module pit_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [3:0]  s_address,
    input  logic [15:0] s_write_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_read_data,
    input  logic [3:0]  m_irq_lines,
    output int          fail_count,
    output int          outstanding,
    output int          ticks_applied,
    output int          timeouts_seen,
    output int          irq_words
);
    timeunit 1ns;
    timeprecision 1ps;

    import pit_pkg::*;

    localparam int MT_W  = 8;
    localparam int CNT_W = 16;

    // Timer state as the block should hold it
    logic                 global_en;
    logic [MAP_CHANS-1:0] chan_en;
    logic [MAP_CHANS-1:0] mux_sel;
    logic [MAP_CHANS-1:0] int_en;
    logic [MAP_CHANS-1:0] flags;
    logic [MT_W-1:0]      mt_load [MAP_MICROS];
    logic [MT_W-1:0]      mt_cnt  [MAP_MICROS];
    logic [CNT_W-1:0]     ch_load [MAP_CHANS];
    logic [CNT_W-1:0]     ch_cnt  [MAP_CHANS];

    // Result words still owed by the block, oldest first
    pit_rsp_t owed_rsp_q[$];

    initial begin
        fail_count    = 0;
        outstanding   = 0;
        ticks_applied = 0;
        timeouts_seen = 0;
        irq_words     = 0;
    end

    // Advance the microtimers by one bus tick and step the channels they trigger
    task automatic advance_tick();
        logic [MAP_MICROS-1:0] fired;
        fired = '0;
        if (global_en) begin
            for (int m = 0; m < MAP_MICROS; m++) begin
                if (mt_cnt[m] == '0) begin
                    mt_cnt[m] = mt_load[m];
                    fired[m]  = 1'b1;
                end else begin
                    mt_cnt[m] = mt_cnt[m] - 1'b1;
                end
            end
            for (int c = 0; c < MAP_CHANS; c++) begin
                if (chan_en[c] && fired[mux_sel[c]]) begin
                    if (ch_cnt[c] == '0) begin
                        ch_cnt[c] = ch_load[c];
                        flags[c]  = 1'b1;
                        timeouts_seen++;
                    end else begin
                        ch_cnt[c] = ch_cnt[c] - 1'b1;
                    end
                end
            end
        end
    endtask

    // Low address bits pick the slot within each group of the map
    function automatic logic [15:0] reg_value(logic [3:0] addr);
        logic [15:0] v;
        v = '0;
        if (addr >= ADDR_COUNT0) begin
            v = ch_cnt[addr[1:0]];
        end else if (addr >= ADDR_LOAD0) begin
            v = ch_load[addr[1:0]];
        end else if (addr >= ADDR_MTLOAD0) begin
            v = 16'(mt_load[addr[0]]);
        end else begin
            case (addr)
                ADDR_ENABLE:  v[GLOBAL_EN_BIT] = global_en;
                ADDR_CHAN_EN: v = 16'(chan_en);
                ADDR_MUX:     v = 16'(mux_sel);
                ADDR_INTE:    v = 16'(int_en);
                ADDR_FLAGS:   v = 16'(flags);
                default:      v = '0;
            endcase
        end
        return v;
    endfunction

    task automatic apply_write(logic [3:0] addr, logic [15:0] data);
        logic [MAP_CHANS-1:0] mask;
        logic                 new_en;
        mask = data[MAP_CHANS-1:0];
        case (addr)
            ADDR_ENABLE: begin
                new_en = data[GLOBAL_EN_BIT];
                // turning the module on reloads every counter
                if (new_en && !global_en) begin
                    for (int m = 0; m < MAP_MICROS; m++) mt_cnt[m] = mt_load[m];
                    for (int c = 0; c < MAP_CHANS; c++) ch_cnt[c] = ch_load[c];
                end
                if (!new_en && global_en) flags = '0;
                global_en = new_en;
                for (int m = 0; m < MAP_MICROS; m++) begin
                    if (data[m]) mt_cnt[m] = mt_load[m];
                end
            end
            ADDR_FORCE: begin
                for (int c = 0; c < MAP_CHANS; c++) begin
                    if (mask[c]) ch_cnt[c] = ch_load[c];
                end
            end
            ADDR_CHAN_EN: begin
                // a channel switched on starts from its load value
                for (int c = 0; c < MAP_CHANS; c++) begin
                    if (mask[c] && !chan_en[c]) ch_cnt[c] = ch_load[c];
                end
                chan_en = mask;
            end
            ADDR_MUX:     mux_sel = mask;
            ADDR_INTE:    int_en  = mask;
            ADDR_FLAGS:   flags   = flags & ~mask;
            ADDR_MTLOAD0,
            ADDR_MTLOAD1: mt_load[addr[0]] = data[MT_W-1:0];
            default: begin
                // count registers are read only
                if (addr >= ADDR_LOAD0 && addr <= ADDR_LOAD3) begin
                    ch_load[addr[1:0]] = data;
                end
            end
        endcase
    endtask

    // Predict on each accepted word, compare each accepted result word
    always @(posedge aclk) begin
        pit_rsp_t want;
        pit_rsp_t oldest;
        if (!aresetn) begin
            global_en = 1'b0;
            chan_en   = '0;
            mux_sel   = '0;
            int_en    = '0;
            flags     = '0;
            for (int m = 0; m < MAP_MICROS; m++) begin
                mt_load[m] = '0;
                mt_cnt[m]  = '0;
            end
            for (int c = 0; c < MAP_CHANS; c++) begin
                ch_load[c] = '0;
                ch_cnt[c]  = '0;
            end
            owed_rsp_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                want.read_data = '0;
                case (s_action)
                    ACT_TICK: begin
                        advance_tick();
                        ticks_applied++;
                    end
                    ACT_READ:  want.read_data = reg_value(s_address);
                    ACT_WRITE: apply_write(s_address, s_write_data);
                    default:   ;
                endcase
                want.irq_lines = flags & int_en;
                owed_rsp_q.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (m_irq_lines != '0) irq_words++;
                if (owed_rsp_q.size() == 0) begin
                    $display("%0t: result word with none expected, read_data %h irq_lines %h",
                             $time, m_read_data, m_irq_lines);
                    fail_count++;
                end else begin
                    oldest = owed_rsp_q.pop_front();
                    if (m_read_data !== oldest.read_data) begin
                        $display("%0t: read_data expected %h, got %h",
                                 $time, oldest.read_data, m_read_data);
                        fail_count++;
                    end
                    if (m_irq_lines !== oldest.irq_lines) begin
                        $display("%0t: irq_lines expected %h, got %h",
                                 $time, oldest.irq_lines, m_irq_lines);
                        fail_count++;
                    end
                end
            end
        end
        outstanding <= owed_rsp_q.size();
    end

endmodule

// File: bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pit_pkg::*;

    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

    localparam int RESET_CYCLES    = 5;
    localparam int WORDS_PER_PHASE = 100;
    localparam int PHASES          = 5;
    localparam int HOLD_CYCLES     = 300;
    localparam int TAIL_CYCLES     = 10;
    localparam int QUIET_LIMIT     = 2000;

    typedef enum {RX_FREE, RX_HALF, RX_SPARSE} rx_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action = '0;
    logic [3:0]  s_address = '0;
    logic [15:0] s_write_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_read_data;
    logic [3:0]  m_irq_lines;

    logic        hold_off_req = 1'b0;
    int          burst_left = 0;
    int          quiet_cycles = 0;

    int          fail_count;
    int          outstanding;
    int          ticks_applied;
    int          timeouts_seen;
    int          irq_words;

    periodic_interrupt_timer_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_address    (s_address),
        .s_write_data (s_write_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .m_irq_lines  (m_irq_lines)
    );

    pit_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_address     (s_address),
        .s_write_data  (s_write_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data),
        .m_irq_lines   (m_irq_lines),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .ticks_applied (ticks_applied),
        .timeouts_seen (timeouts_seen),
        .irq_words     (irq_words)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Offer one word, opening a new burst after a random gap when the last one ran out
    task automatic issue(input logic [1:0] act, input logic [3:0] addr,
                         input logic [15:0] data);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_valid      <= 1'b1;
        s_action     <= act;
        s_address    <= addr;
        s_write_data <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Hold the input idle until every owed result word has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // Program loads, routing, interrupt enables and switch the timer on
    task automatic setup_timers(input bit wide);
        for (int m = 0; m < MAP_MICROS; m++) begin
            issue(ACT_WRITE, ADDR_MTLOAD0 + 4'(m),
                  wide ? 16'($urandom) : 16'($urandom_range(0, 3)));
        end
        for (int c = 0; c < MAP_CHANS; c++) begin
            issue(ACT_WRITE, ADDR_LOAD0 + 4'(c),
                  wide ? 16'($urandom) : 16'($urandom_range(0, 9)));
        end
        issue(ACT_WRITE, ADDR_MUX, 16'($urandom));
        issue(ACT_WRITE, ADDR_INTE, 16'($urandom) | 16'h0001);
        issue(ACT_WRITE, ADDR_CHAN_EN, 16'($urandom) | 16'h0001);
        issue(ACT_WRITE, ADDR_ENABLE, 16'($urandom) | (16'(1) << GLOBAL_EN_BIT));
    endtask

    // Mostly ticks so the channels run, with reads and writes spread over the map
    task automatic random_word();
        int unsigned pick;
        logic [1:0]  act;
        logic [3:0]  addr;
        logic [15:0] data;
        pick = $urandom_range(0, 99);
        addr = 4'($urandom_range(0, 15));
        data = 16'($urandom);
        if (pick < 60) begin
            act = ACT_TICK;
        end else if (pick < 78) begin
            act = ACT_READ;
        end else if (pick < 97) begin
            act = ACT_WRITE;
            // keep the timer mostly on and the periods short
            if (addr == ADDR_ENABLE) begin
                data[GLOBAL_EN_BIT] = ($urandom_range(0, 9) != 0);
            end else if (addr >= ADDR_MTLOAD0 && addr <= ADDR_MTLOAD1) begin
                if ($urandom_range(0, 3) != 0) data = 16'($urandom_range(0, 3));
            end else if (addr >= ADDR_LOAD0 && addr <= ADDR_LOAD3) begin
                if ($urandom_range(0, 3) != 0) data = 16'($urandom_range(0, 6));
            end
        end else begin
            act = ACT_SPARE;
        end
        issue(act, addr, data);
    endtask

    // Receiver: stall pattern of its own, plus one long hold-off on request
    initial begin
        rx_mode_t rx_mode;
        int       seg_left;
        bit       hold_done;
        rx_mode   = RX_FREE;
        seg_left  = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (seg_left == 0) begin
                    rx_mode  = rx_mode_t'($urandom_range(0, 2));
                    seg_left = $urandom_range(10, 60);
                end
                seg_left--;
                case (rx_mode)
                    RX_FREE:   m_ready <= 1'b1;
                    RX_HALF:   m_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= 1'b1;
                endcase
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    // Sender: reset, directed words, then random phases
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // load register widths and masking
        issue(ACT_WRITE, ADDR_MTLOAD0, 16'hFFFF);
        issue(ACT_READ,  ADDR_MTLOAD0, 16'h0000);
        issue(ACT_WRITE, ADDR_MTLOAD0, 16'h0000);
        issue(ACT_WRITE, ADDR_MTLOAD1, 16'h0001);
        issue(ACT_WRITE, ADDR_LOAD0,   16'hFFFF);
        issue(ACT_READ,  ADDR_LOAD0,   16'h0000);
        issue(ACT_WRITE, ADDR_LOAD0 + 4'd1, 16'h0000);
        issue(ACT_WRITE, ADDR_LOAD0 + 4'd2, 16'h0002);
        issue(ACT_WRITE, ADDR_LOAD3,   16'h0001);
        issue(ACT_WRITE, ADDR_MUX,     16'hFFFA);
        issue(ACT_WRITE, ADDR_INTE,    16'hFFFF);
        // a tick while the module is off changes nothing
        issue(ACT_TICK,  ADDR_ENABLE,  16'hFFFF);
        // channels switched on load their counts
        issue(ACT_WRITE, ADDR_CHAN_EN, 16'h000F);
        // module on, with both microtimers force-loaded
        issue(ACT_WRITE, ADDR_ENABLE,  (16'(1) << GLOBAL_EN_BIT) | 16'h0003);
        repeat (4) issue(ACT_TICK, ADDR_FLAGS, 16'h0000);
        issue(ACT_READ,  ADDR_FLAGS,   16'h0000);
        issue(ACT_WRITE, ADDR_FLAGS,   16'h0005);
        // count registers ignore writes
        issue(ACT_WRITE, ADDR_COUNT0,  16'h1234);
        issue(ACT_READ,  ADDR_COUNT0,  16'h0000);
        issue(ACT_WRITE, ADDR_FORCE,   16'hFFFF);
        issue(ACT_SPARE, ADDR_COUNT3,  16'hFFFF);
        issue(ACT_READ,  ADDR_FORCE,   16'h0000);
        // module off clears the flags
        issue(ACT_WRITE, ADDR_ENABLE,  16'h0000);
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            setup_timers(phase == PHASES - 1);
            if (phase == 1) hold_off_req <= 1'b1;
            repeat (WORDS_PER_PHASE) random_word();
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Covered %0d ticks and %0d channel time-outs; %0d result words raised interrupts,",
                 ticks_applied, timeouts_seen, irq_words);
        $display("with one long output hold-off and drained pauses between %0d phases.",
                 PHASES);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/pit_pkg.sv
hw/rtl/pit_core.sv
hw/rtl/periodic_interrupt_timer_top.sv
bench/pit_checker.sv
bench/tb.sv
